// ----- src/u8fold_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fold_pkg
// Shared types, codes and fold tables for the UTF-8 to ASCII folding unit.
// ----------------------------------------------------------------------------
package u8fold_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHARS  = 1'd1;

    localparam logic       LOWER_CASE_RST = 1'b1;
    localparam logic [7:0] MAX_CHARS_RST  = 8'd39;

    // Two-byte leads that fold
    localparam logic [7:0] LEAD_LATIN1  = 8'hC3;
    localparam logic [7:0] LEAD_EXT_A_0 = 8'hC4;
    localparam logic [7:0] LEAD_EXT_A_1 = 8'hC5;

    // Continuation bytes to drop after multi-byte leads
    localparam logic [1:0] SKIP_THREE_BYTE = 2'd2;
    localparam logic [1:0] SKIP_FOUR_BYTE  = 2'd3;

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_UPPER_Z = 7'h5A;
    localparam logic [6:0] ASCII_CASE_BIT = 7'h20;
    localparam logic [7:0] NO_FOLD_MARK = 8'h2E;

    // Latin-1 supplement C3 80..BF
    localparam logic [0:63][7:0] LATIN1_FOLD =
        {"AAAAAAECEEEEIIIIDNOOOOOxOUUUUYPs", "aaaaaaeceeeeiiiidnooooo/ouuuuypy"};

    // Latin Extended-A, U+0100..U+017F; '.' has no fold
    localparam logic [0:127][7:0] EXT_A_FOLD =
        {"AaAaAaCcCcCcCcDd", "DdEeEeEeEeEeGgGg",
         "GgGg....IiIiIiIi", "Ii.......LlLlLl.",
         ".LlNnNnNn...OoOo", "Oo..RrRrRrSsSsSs",
         "SsTtTtTtUuUuUuUu", "UuUu..yy.ZzZzZz."};

    typedef struct packed {
        logic [7:0] byte_in;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_out;
        logic       out_end;
    } out_item_t;

    typedef struct packed {
        logic       lower_case;
        logic [7:0] max_output_chars;
    } cfg_t;

endpackage

// ----- src/u8fold_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fold_fold
// Folds a held C3/C4/C5 lead and its second byte to one ASCII character or 0.
// ----------------------------------------------------------------------------
module u8fold_fold (
    input  logic [7:0] lead,
    input  logic [7:0] second,
    output logic [6:0] ch
);

    logic [7:0] ext_entry;

    always_comb
    begin
        ext_entry = u8fold_pkg::EXT_A_FOLD[{lead[0], second[5:0]}];
        ch = '0;
        case (lead)
            u8fold_pkg::LEAD_LATIN1:
            begin
                // needs a real continuation byte
                if (second[7:6] == 2'b10)
                    ch = u8fold_pkg::LATIN1_FOLD[second[5:0]][6:0];
            end
            u8fold_pkg::LEAD_EXT_A_0, u8fold_pkg::LEAD_EXT_A_1:
            begin
                // second byte taken unchecked, low six bits only
                if (ext_entry != u8fold_pkg::NO_FOLD_MARK)
                    ch = ext_entry[6:0];
            end
            default:
                ch = '0;
        endcase
    end

endmodule

// ----- src/u8fold_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fold_decode
// Per-byte decode: lead/skip/count state and the result for one byte.
// ----------------------------------------------------------------------------
module u8fold_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  u8fold_pkg::in_item_t  item,
    input  u8fold_pkg::cfg_t      cfg,
    output u8fold_pkg::out_item_t result
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic [1:0] skip_reg;
    logic [1:0] skip_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [6:0] fold_ch;
    logic [6:0] ch;
    logic [6:0] ch_cased;
    logic       emit;

    u8fold_fold u_fold (
        .lead   (pend_reg),
        .second (item.byte_in),
        .ch     (fold_ch)
    );

    always_comb
    begin
        ch         = '0;
        pend_next  = pend_reg;
        skip_next  = skip_reg;
        count_next = count_reg;

        if (skip_reg != 2'd0)
            skip_next = skip_reg - 2'd1;
        else if (pend_reg != 8'd0)
        begin
            ch        = fold_ch;
            pend_next = '0;
        end
        else if (!item.byte_in[7])
            ch = item.byte_in[6:0];
        else if (item.byte_in[7:5] == 3'b110)
        begin
            // lead as last byte is dropped
            if (!item.string_end)
                pend_next = item.byte_in;
        end
        else if (item.byte_in[7:4] == 4'b1110)
            skip_next = u8fold_pkg::SKIP_THREE_BYTE;
        else if (item.byte_in[7:3] == 5'b11110)
            skip_next = u8fold_pkg::SKIP_FOUR_BYTE;

        emit = (ch != 7'd0) && (count_reg < cfg.max_output_chars);

        if (cfg.lower_case
            && (ch inside {[u8fold_pkg::ASCII_UPPER_A:u8fold_pkg::ASCII_UPPER_Z]}))
            ch_cased = ch | u8fold_pkg::ASCII_CASE_BIT;
        else
            ch_cased = ch;

        if (emit)
            count_next = count_reg + 8'd1;

        if (item.string_end)
        begin
            pend_next  = '0;
            skip_next  = '0;
            count_next = '0;
        end

        result.char_valid = emit;
        result.char_out   = emit ? ch_cased : 7'd0;
        result.out_end    = item.string_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            skip_reg  <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            pend_reg  <= pend_next;
            skip_reg  <= skip_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/utf8_latin_fold_to_ascii_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_latin_fold_to_ascii_unit
// Folds a UTF-8 byte stream to ASCII, one result per input byte.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction  Moves
//  src      src_valid / src_stall / src_item  in         one string byte + end flag
//  res      res_valid / res_stall / res_item  out        char_valid, char_out, out_end
//  cfg      cfg_we / cfg_index / cfg_data     in         register write, no handshake
//
//  One byte per cycle sustained while res_stall stays low; each byte passes the
//  input register, then the result register fed by the decode and fold logic.
//  Reset clears the decode state and restores lower_case = 1, limit = 39.
//  A stalled result holds; the input register holds behind it and src_stall
//  rises only when both registers are full and res_stall is high.
// ----------------------------------------------------------------------------
module utf8_latin_fold_to_ascii_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 src_valid,
    output logic                                 src_stall,
    input  u8fold_pkg::in_item_t                 src_item,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output u8fold_pkg::out_item_t                res_item,
    input  logic                                 cfg_we,
    input  logic [u8fold_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [u8fold_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration registers
    logic                  lower_case_reg;
    logic [7:0]            max_chars_reg;
    u8fold_pkg::cfg_t      cfg;

    // input stage
    logic                  s1_valid_reg;
    u8fold_pkg::in_item_t  s1_item_reg;

    // result stage
    logic                  res_valid_reg;
    u8fold_pkg::out_item_t res_item_reg;
    u8fold_pkg::out_item_t dec_result;

    logic res_hold;
    logic advance;
    logic src_take;

    // result register is busy while a transfer is stalled on it
    assign res_hold  = res_valid_reg && res_stall;
    // input byte moves into the result register
    assign advance   = s1_valid_reg && !res_hold;
    assign src_stall = s1_valid_reg && res_hold;
    assign src_take  = src_valid && !src_stall;

    assign cfg.lower_case       = lower_case_reg;
    assign cfg.max_output_chars = max_chars_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_case_reg <= u8fold_pkg::LOWER_CASE_RST;
            max_chars_reg  <= u8fold_pkg::MAX_CHARS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                u8fold_pkg::CFG_LOWER_CASE: lower_case_reg <= cfg_data[0];
                u8fold_pkg::CFG_MAX_CHARS:  max_chars_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (src_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (src_take)
            s1_item_reg <= src_item;
        if (advance)
            res_item_reg <= dec_result;
    end

    u8fold_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (dec_result)
    );

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // an item leaving the input stage always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("item lost between input and result registers");

    // no character means a zero code
    a_idle_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_item_reg.char_valid |-> res_item_reg.char_out == 7'd0)
        else $error("char_out nonzero without char_valid");

    // an emitted character is never NUL
    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.char_valid |-> res_item_reg.char_out != 7'd0)
        else $error("emitted NUL character");

    // stall only when the input and result stages are both full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> s1_valid_reg && res_valid_reg)
        else $error("input stalled with free stages");

endmodule

// ----- dv/u8fold_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8fold_checker
// Watches the byte and result transfers of the folding unit, folds every
// accepted byte with its own decoder state and compares results in order.
// ----------------------------------------------------------------------------
module u8fold_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    input  logic                              src_stall,
    input  u8fold_pkg::in_item_t              src_item,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  u8fold_pkg::out_item_t             res_item,
    input  logic                              cfg_we,
    input  logic [u8fold_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [u8fold_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                fail_count,
    output int                                pending_results
);

    // Base letters, kept apart from the design's own tables
    localparam logic [0:63][7:0] LATIN1_BASE =
        {"AAAAAAECEEEEIIIIDNOOOOOxOUUUUYPs", "aaaaaaeceeeeiiiidnooooo/ouuuuypy"};
    localparam logic [0:127][7:0] EXT_A_BASE =
        {"AaAaAaCcCcCcCcDd", "DdEeEeEeEeEeGgGg",
         "GgGg....IiIiIiIi", "Ii.......LlLlLl.",
         ".LlNnNnNn...OoOo", "Oo..RrRrRrSsSsSs",
         "SsTtTtTtUuUuUuUu", "UuUu..yy.ZzZzZz."};
    localparam logic [7:0] NO_BASE     = ".";
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Register copies and decoder state
    logic       lower_en;
    logic [7:0] char_cap;
    logic [7:0] held_lead;
    logic [1:0] skip_left;
    logic [7:0] emitted;

    u8fold_pkg::out_item_t folded_due[$];
    int                    mismatches;

    function automatic logic [7:0] base_letter(input logic [7:0] lead,
                                               input logic [7:0] trail);
        logic [10:0] code_point;
        logic [7:0]  letter;
        letter = 8'h00;
        if (lead == u8fold_pkg::LEAD_LATIN1)
        begin
            if (trail[7:6] == 2'b10)
                letter = LATIN1_BASE[trail[5:0]];
        end
        else if (lead == u8fold_pkg::LEAD_EXT_A_0 || lead == u8fold_pkg::LEAD_EXT_A_1)
        begin
            // trail used unchecked; offset from U+0100 is the low seven bits
            code_point = {lead[4:0], trail[5:0]};
            letter = EXT_A_BASE[code_point[6:0]];
            if (letter == NO_BASE)
                letter = 8'h00;
        end
        return letter;
    endfunction

    function automatic u8fold_pkg::out_item_t fold_next_byte(input logic [7:0] value,
                                                             input logic last);
        logic [7:0]            ch;
        u8fold_pkg::out_item_t folded;
        ch = 8'h00;
        folded = '0;
        if (skip_left != 2'd0)
            skip_left = skip_left - 2'd1;
        else if (held_lead != 8'h00)
        begin
            ch = base_letter(held_lead, value);
            held_lead = 8'h00;
        end
        else if (!value[7])
            ch = value;
        else if (value[7:5] == 3'b110)
        begin
            if (!last)
                held_lead = value;
        end
        else if (value[7:4] == 4'b1110)
            skip_left = 2'd2;
        else if (value[7:3] == 5'b11110)
            skip_left = 2'd3;

        if (ch != 8'h00 && emitted < char_cap)
        begin
            if (lower_en && ch >= "A" && ch <= "Z")
                ch = ch + CASE_OFFSET;
            folded.char_valid = 1'b1;
            folded.char_out = ch[6:0];
            emitted = emitted + 8'd1;
        end
        folded.out_end = last;

        if (last)
        begin
            held_lead = 8'h00;
            skip_left = 2'd0;
            emitted = 8'h00;
        end
        return folded;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        u8fold_pkg::out_item_t due;
        if (!rst_n)
        begin
            lower_en = 1'b1;
            char_cap = 8'd39;
            held_lead = 8'h00;
            skip_left = 2'd0;
            emitted = 8'h00;
            folded_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    u8fold_pkg::CFG_LOWER_CASE: lower_en = cfg_data[0];
                    u8fold_pkg::CFG_MAX_CHARS:  char_cap = cfg_data;
                    default: ;
                endcase
            end

            if (res_valid && !res_stall)
            begin
                if (folded_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing due: expected none, actual %h",
                             $time, res_item);
                end
                else
                begin
                    due = folded_due.pop_front();
                    if (res_item.char_valid !== due.char_valid)
                    begin
                        mismatches++;
                        $display("%0t: char_valid expected %b actual %b",
                                 $time, due.char_valid, res_item.char_valid);
                    end
                    if (res_item.char_out !== due.char_out)
                    begin
                        mismatches++;
                        $display("%0t: char_out expected %h actual %h",
                                 $time, due.char_out, res_item.char_out);
                    end
                    if (res_item.out_end !== due.out_end)
                    begin
                        mismatches++;
                        $display("%0t: out_end expected %b actual %b",
                                 $time, due.out_end, res_item.out_end);
                    end
                end
            end

            if (src_valid && !src_stall)
                folded_due.push_back(fold_next_byte(src_item.byte_in, src_item.string_end));

            fail_count <= mismatches;
            pending_results <= folded_due.size();
        end
    end

endmodule

// ----- dv/tb_utf8_latin_fold_to_ascii_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_latin_fold_to_ascii_unit
// Drives UTF-8 strings byte by byte into the folding unit under random
// stalls on both channels and across several register settings; the checker
// beside the unit predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_utf8_latin_fold_to_ascii_unit;

    localparam int BYTES_PER_PHASE = 215;  // eight phases, about 1700 bytes
    localparam int BACKLOG_CYCLES  = 48;   // long receiver hold-off
    localparam int TAIL_CYCLES     = 8;    // margin after the final drain
    localparam int N_DIRECTED      = 28;

    // Directed strings, in order:
    //   ASCII boundary values and the zero byte;
    //   C3 pairs at both ends of the table and with a non-continuation trail,
    //   C4/C5 pairs incl. a point with no fold and an unchecked trail,
    //   another two-byte lead, a three-byte sequence;
    //   stray continuation and F8..FF bytes;
    //   a four-byte lead cut short by string end (skip ends there);
    //   a lone lead as the last byte.
    localparam logic [0:N_DIRECTED-1][7:0] DIRECTED_BYTES = {
        8'h41, 8'h7F, 8'h00, 8'h01,
        8'hC3, 8'h80, 8'hC3, 8'hBF, 8'hC3, 8'h7F, 8'hC4, 8'h80,
        8'hC5, 8'hBF, 8'hC4, 8'h41, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
        8'h80, 8'hFF, 8'hF8,
        8'hF0, 8'h9F, 8'h98,
        8'hC3};
    localparam logic [0:N_DIRECTED-1] DIRECTED_ENDS =
        28'b0001_00000000000000001_001_001_1;

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 src_valid = 1'b0;
    logic                                 src_stall;
    u8fold_pkg::in_item_t                 src_item  = '0;
    logic                                 res_valid;
    logic                                 res_stall = 1'b0;
    u8fold_pkg::out_item_t                res_item;
    logic                                 cfg_we    = 1'b0;
    logic [u8fold_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [u8fold_pkg::CFG_DATA_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending_results;

    // Shared with the receiver: idle percentage for both sides, and a ticket
    // count for long hold-offs (stimulus raises it, receiver catches up).
    int idle_pct       = 30;
    int backlog_asked  = 0;
    int backlog_served = 0;

    logic [7:0] text_bytes[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utf8_latin_fold_to_ascii_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    u8fold_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .src_valid       (src_valid),
        .src_stall       (src_stall),
        .src_item        (src_item),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res_item        (res_item),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // One byte transfer. An optional random gap first with valid low,
    // then hold the payload until the unit takes it. Returns at the edge of
    // the transfer, so a following call with no gap keeps valid high without a dip.
    task automatic push_byte(input logic [7:0] value, input logic last);
        u8fold_pkg::in_item_t item;
        item.byte_in = value;
        item.string_end = last;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        src_item <= item;
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    // Sender stops and waits until every result due has been taken.
    task automatic wait_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [u8fold_pkg::CFG_IDX_W-1:0] index,
                             input logic [u8fold_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_cont();
        logic [5:0] low;
        low = 6'($urandom_range(63));
        return {2'b10, low};
    endfunction

    // Builds one string, mostly well-formed UTF-8 with random content, plus
    // some noise: stray bytes, bad trails, cut-short sequences and a lone
    // lead at the end. Then sends it with the end flag on its last byte.
    task automatic send_random_string(inout int sent);
        int         n_chars;
        int         kind;
        int         i;
        int         k;
        logic [7:0] b;
        text_bytes.delete();
        n_chars = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (i = 0; i < n_chars; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                b = 8'($urandom_range(1, 127));
                if ($urandom_range(39) == 0)
                    b = 8'h00;
                text_bytes.push_back(b);
            end
            else if (kind < 48)
            begin
                text_bytes.push_back(u8fold_pkg::LEAD_LATIN1);
                text_bytes.push_back(rand_cont());
            end
            else if (kind < 62)
            begin
                text_bytes.push_back($urandom_range(1) ? u8fold_pkg::LEAD_EXT_A_1
                                                       : u8fold_pkg::LEAD_EXT_A_0);
                text_bytes.push_back(rand_cont());
            end
            else if (kind < 68)
            begin
                b = 8'($urandom_range(8'hC0, 8'hDF));
                text_bytes.push_back(b);
                text_bytes.push_back(rand_cont());
            end
            else if (kind < 76)
            begin
                b = 8'($urandom_range(8'hE0, 8'hEF));
                text_bytes.push_back(b);
                for (k = 0; k < 2; k++)
                    text_bytes.push_back(rand_cont());
            end
            else if (kind < 82)
            begin
                b = 8'($urandom_range(8'hF0, 8'hF7));
                text_bytes.push_back(b);
                for (k = 0; k < 3; k++)
                    text_bytes.push_back(rand_cont());
            end
            else if (kind < 86)
                text_bytes.push_back(rand_cont());
            else if (kind < 89)
            begin
                b = 8'($urandom_range(8'hF8, 8'hFF));
                text_bytes.push_back(b);
            end
            else if (kind < 95)
            begin
                // two-byte lead with an arbitrary trail, any value at all
                if ($urandom_range(1))
                    b = 8'($urandom_range(8'hC3, 8'hC5));
                else
                    b = 8'($urandom_range(8'hC0, 8'hDF));
                text_bytes.push_back(b);
                b = 8'($urandom_range(255));
                text_bytes.push_back(b);
            end
            else
            begin
                // multi-byte lead cut short
                b = 8'($urandom_range(8'hE0, 8'hF7));
                text_bytes.push_back(b);
                if ($urandom_range(1))
                    text_bytes.push_back(rand_cont());
            end
        end
        if ($urandom_range(9) == 0)
        begin
            b = 8'($urandom_range(8'hC0, 8'hDF));
            text_bytes.push_back(b);
        end
        for (i = 0; i < text_bytes.size(); i++)
            push_byte(text_bytes[i], i == text_bytes.size() - 1);
        sent += text_bytes.size();
    endtask

    // One register setting: drain, write both registers, then random strings.
    task automatic run_phase(input logic lower, input logic [7:0] cap,
                             input int idle, input bit backlog);
        int sent;
        wait_drained();
        write_reg(u8fold_pkg::CFG_LOWER_CASE, {7'd0, lower});
        write_reg(u8fold_pkg::CFG_MAX_CHARS, cap);
        idle_pct = idle;
        if (backlog)
            backlog_asked++;
        sent = 0;
        while (sent < BYTES_PER_PHASE)
            send_random_string(sent);
    endtask

    // Receiver: random stall per cycle, or a long hold-off on request so that
    // both unit registers fill and the input transfer stalls behind them.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (backlog_asked != backlog_served)
            begin
                backlog_served = backlog_asked;
                res_stall <= 1'b1;
                repeat (BACKLOG_CYCLES) @(posedge clk);
            end
            else
                res_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
        end
    end

    initial
    begin : stimulus
        int i;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings (lower case on, limit 39) for the directed strings
        for (i = 0; i < N_DIRECTED; i++)
            push_byte(DIRECTED_BYTES[i], DIRECTED_ENDS[i]);

        // Settings sweep: both limit extremes, small limits that bite often,
        // a calm phase with no idling, and two long receiver hold-offs.
        run_phase(1'b0, 8'd255, 30, 1'b0);
        run_phase(1'b1, 8'd0,   30, 1'b0);
        run_phase(1'b0, 8'd1,   30, 1'b1);
        run_phase(1'b1, 8'd3,   0,  1'b0);
        run_phase(1'b0, 8'd39,  30, 1'b0);
        run_phase(1'b1, 8'd255, 30, 1'b1);
        run_phase(1'b0, 8'd0,   30, 1'b0);
        run_phase(1'b1, 8'd17,  30, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
